@@ rtl/core/assert_macros.svh @@
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked at every rising edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Implication whose consequent is checked in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

@@ rtl/core/mrr_pkg.sv @@
`default_nettype none
package mrr_pkg;
    localparam int NUM_BITS = 63;
    localparam int CNT_W = $clog2(NUM_BITS + 1);

    typedef logic [NUM_BITS-1:0] val_t;
    typedef logic [CNT_W-1:0] cnt_t;

    localparam logic [1:0] V_COMPOSITE = 2'd0;
    localparam logic [1:0] V_PROBABLE  = 2'd1;
    localparam logic [1:0] V_PRIME     = 2'd2;
    localparam logic [1:0] V_BADBASE   = 2'd3;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHECK,
        ST_SPLIT,
        ST_POW_MUL,
        ST_POW_MWAIT,
        ST_POW_SQ,
        ST_POW_SWAIT,
        ST_TEST,
        ST_SQ,
        ST_SQ_WAIT,
        ST_DONE
    } state_t;
endpackage
`default_nettype wire

@@ rtl/core/mrr_mulmod.sv @@
`default_nettype none
// Interleaved shift-and-add modular multiplier, one multiplier bit per cycle.
module mrr_mulmod
(
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           go,
    input  wire mrr_pkg::val_t  x,
    input  wire mrr_pkg::val_t  y,
    input  wire mrr_pkg::val_t  m,
    output logic                done,
    output mrr_pkg::val_t       prod
);
    localparam int W = mrr_pkg::NUM_BITS;

    logic          run_reg, run_next;
    mrr_pkg::cnt_t idx_reg, idx_next;
    mrr_pkg::val_t acc_reg, acc_next;
    mrr_pkg::val_t x_reg, y_reg, m_reg;
    logic          done_reg, done_next;

    logic [W:0] dbl, dsum, sum, ssum;
    mrr_pkg::val_t acc_d;

    always_comb
    begin
        dbl   = {acc_reg, 1'b0};
        dsum  = dbl - {1'b0, m_reg};
        acc_d = dsum[W] ? acc_reg << 1 : dsum[W-1:0];
        sum   = {1'b0, acc_d} + {1'b0, x_reg};
        ssum  = sum - {1'b0, m_reg};
        acc_next = acc_reg;
        if (run_reg)
        begin
            if (y_reg[idx_reg[$clog2(W)-1:0]])
                acc_next = ssum[W] ? sum[W-1:0] : ssum[W-1:0];
            else
                acc_next = acc_d;
        end
        if (go)
            acc_next = '0;
        run_next  = run_reg;
        idx_next  = idx_reg;
        done_next = 1'b0;
        if (go)
        begin
            run_next = 1'b1;
            idx_next = mrr_pkg::cnt_t'(W - 1);
        end
        else if (run_reg)
        begin
            if (idx_reg == '0)
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
            else
                idx_next = idx_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            idx_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            idx_reg  <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        if (go)
        begin
            x_reg <= x;
            y_reg <= y;
            m_reg <= m;
        end
    end

    assign done = done_reg;
    assign prod = acc_reg;
endmodule
`default_nettype wire

@@ rtl/core/miller_rabin_round_core.sv @@
`default_nettype none
// One Miller-Rabin round on a 63-bit candidate with one witness base. Pulse
// start while busy is low; verdict appears with done high for exactly one
// cycle and must be captured then, as the receiver cannot stall the block.
// Candidates 2 and 3 give prime, 0, 1 and even ones give not prime, and a
// base outside 2..n-2 gives base out of range, all decided in the check
// state. Other candidates run square-and-multiply then up to r-1 squarings
// through one shared modular multiplier; a product is formed by a launch,
// one bit step per multiplier bit and a result. Each bit of the odd part d
// of n-1 costs a multiply and a squaring when set and a squaring when clear.
// busy stays high through the verdict cycle.
`include "assert_macros.svh"
module miller_rabin_round_core
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [62:0] candidate,
    input  wire logic [62:0] witness_base,
    output logic             done,
    output logic [1:0]       verdict
);
    mrr_pkg::state_t state_reg, state_next;
    mrr_pkg::val_t   n_reg, n_next, b_reg, b_next, d_reg, d_next, g_reg, g_next;
    mrr_pkg::cnt_t   r_reg, r_next;
    logic [1:0]      v_reg, v_next;

    logic          mul_go, mul_done;
    mrr_pkg::val_t mul_x, mul_y, mul_prod, nm1;

    mrr_mulmod u_mul
    (
        .clk   (clk),
        .rst_n (rst_n),
        .go    (mul_go),
        .x     (mul_x),
        .y     (mul_y),
        .m     (n_reg),
        .done  (mul_done),
        .prod  (mul_prod)
    );

    assign nm1 = n_reg - 1'b1;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            mrr_pkg::ST_IDLE:      if (start) state_next = mrr_pkg::ST_CHECK;
            mrr_pkg::ST_CHECK:
            begin
                if (n_reg == 63'd2 || n_reg == 63'd3 || n_reg < 63'd2 || !n_reg[0]
                    || b_reg < 63'd2 || b_reg > n_reg - 63'd2)
                    state_next = mrr_pkg::ST_DONE;
                else
                    state_next = mrr_pkg::ST_SPLIT;
            end
            mrr_pkg::ST_SPLIT:     if (d_reg[0]) state_next = mrr_pkg::ST_POW_MUL;
            mrr_pkg::ST_POW_MUL:
            begin
                if (d_reg == '0)
                    state_next = mrr_pkg::ST_TEST;
                else if (d_reg[0])
                    state_next = mrr_pkg::ST_POW_MWAIT;
                else
                    state_next = mrr_pkg::ST_POW_SQ;
            end
            mrr_pkg::ST_POW_MWAIT: if (mul_done) state_next = mrr_pkg::ST_POW_SQ;
            mrr_pkg::ST_POW_SQ:    state_next = mrr_pkg::ST_POW_SWAIT;
            mrr_pkg::ST_POW_SWAIT: if (mul_done) state_next = mrr_pkg::ST_POW_MUL;
            mrr_pkg::ST_TEST:
            begin
                if (g_reg == 63'd1 || g_reg == nm1 || r_reg <= mrr_pkg::cnt_t'(1))
                    state_next = mrr_pkg::ST_DONE;
                else
                    state_next = mrr_pkg::ST_SQ;
            end
            mrr_pkg::ST_SQ:        state_next = mrr_pkg::ST_SQ_WAIT;
            mrr_pkg::ST_SQ_WAIT:
            begin
                if (mul_done)
                begin
                    if (mul_prod == nm1 || r_reg <= mrr_pkg::cnt_t'(2))
                        state_next = mrr_pkg::ST_DONE;
                    else
                        state_next = mrr_pkg::ST_SQ;
                end
            end
            mrr_pkg::ST_DONE:      state_next = mrr_pkg::ST_IDLE;
            default:               state_next = mrr_pkg::ST_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        n_next = n_reg;
        b_next = b_reg;
        d_next = d_reg;
        g_next = g_reg;
        r_next = r_reg;
        v_next = v_reg;
        mul_go = 1'b0;
        mul_x  = g_reg;
        mul_y  = b_reg;
        case (state_reg)
            mrr_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    n_next = candidate;
                    b_next = witness_base;
                end
            end
            mrr_pkg::ST_CHECK:
            begin
                d_next = nm1;
                r_next = '0;
                g_next = 63'd1;
                if (n_reg == 63'd2 || n_reg == 63'd3)
                    v_next = mrr_pkg::V_PRIME;
                else if (n_reg < 63'd2 || !n_reg[0])
                    v_next = mrr_pkg::V_COMPOSITE;
                else
                    v_next = mrr_pkg::V_BADBASE;
            end
            mrr_pkg::ST_SPLIT:
            begin
                // strip trailing zeros of n-1, one per cycle
                if (!d_reg[0])
                begin
                    d_next = d_reg >> 1;
                    r_next = r_reg + 1'b1;
                end
            end
            mrr_pkg::ST_POW_MUL:
            begin
                if (d_reg != '0 && d_reg[0])
                begin
                    mul_go = 1'b1;
                    mul_x  = g_reg;
                    mul_y  = b_reg;
                end
            end
            mrr_pkg::ST_POW_MWAIT: if (mul_done) g_next = mul_prod;
            mrr_pkg::ST_POW_SQ:
            begin
                mul_go = 1'b1;
                mul_x  = b_reg;
                mul_y  = b_reg;
                d_next = d_reg >> 1;
            end
            mrr_pkg::ST_POW_SWAIT: if (mul_done) b_next = mul_prod;
            mrr_pkg::ST_TEST:
            begin
                if (g_reg == 63'd1 || g_reg == nm1)
                    v_next = mrr_pkg::V_PROBABLE;
                else
                    v_next = mrr_pkg::V_COMPOSITE;
            end
            mrr_pkg::ST_SQ:
            begin
                mul_go = 1'b1;
                mul_x  = g_reg;
                mul_y  = g_reg;
            end
            mrr_pkg::ST_SQ_WAIT:
            begin
                if (mul_done)
                begin
                    g_next = mul_prod;
                    r_next = r_reg - 1'b1;
                    if (mul_prod == nm1)
                        v_next = mrr_pkg::V_PROBABLE;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= mrr_pkg::ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        n_reg <= n_next;
        b_reg <= b_next;
        d_reg <= d_next;
        g_reg <= g_next;
        r_reg <= r_next;
        v_reg <= v_next;
    end

    assign busy    = (state_reg != mrr_pkg::ST_IDLE);
    assign done    = (state_reg == mrr_pkg::ST_DONE);
    assign verdict = v_reg;

    `ASSERT_NEXT(a_done_then_idle, clk, rst_n, done, !busy)
    `ASSERT_IMPL(a_done_busy, clk, rst_n, done, busy)
    `ASSERT_IMPL(a_mul_only_busy, clk, rst_n, mul_go, busy && !done)
    `ASSERT_NEXT(a_start_busy, clk, rst_n, start && !busy, busy && !done)
endmodule
`default_nettype wire
